@@ design/ae16_pkg.sv @@
// ----------------------------------------------------------------------------
// ae16_pkg
// Types, constants and state codes shared by the arithmetic encoder modules.
// ----------------------------------------------------------------------------
package ae16_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int CODE_BITS_DEF    = 16;
  localparam int CUM_W            = 14;
  localparam int SYM_W            = 8;
  localparam int CNT_W            = 16;
  localparam int MAX_RESULTS      = 16;
  localparam logic [CNT_W-1:0] PENDING_MAX = 16'hFFFF;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [SYM_W-1:0] symbol;
    logic [CUM_W-1:0] cum_low;
    logic [CUM_W-1:0] cum_high;
  } ae16_in_t;

  typedef struct packed {
    logic             lead_bit;
    logic [CNT_W-1:0] follow_count;
    logic             last_of_run;
  } ae16_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_RENORM,
    ST_EMIT,
    ST_FLUSH
  } ae16_state_t;

endpackage

@@ design/ae16_ram.sv @@
// ----------------------------------------------------------------------------
// ae16_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ae16_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/ae16_div.sv @@
// ----------------------------------------------------------------------------
// ae16_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ae16_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ design/arithmetic_encoder_16bit_core.sv @@
// ----------------------------------------------------------------------------
// arithmetic_encoder_16bit_core
// Integer arithmetic encoder with a static cumulative-bound table.
// ----------------------------------------------------------------------------
// A load item writes one symbol's bounds into the table RAM in its accept
// cycle, so loads can follow back to back. An encode item reads the table,
// multiplies both bounds by the range, runs two divisions by the programmed
// total (zero taken as one) on a shared bit-serial divider, clamps the
// offsets and then renormalizes at one shift per cycle while the output is
// not stalled, up to CODE_BITS + 1 shifts, with each decided bit (at most
// MAX_RESULTS per encode) leaving as one output item; the FLUSH state
// releases the final item with last_of_run set. Items whose symbol is not
// below SYMBOL_COUNT are accepted and dropped. The input is ready again when
// FLUSH ends, which waits while the output stalls; one item is in work at a
// time, and the divider sets the rate unless the output stalls.
module arithmetic_encoder_16bit_core
  import ae16_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int CODE_BITS    = CODE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ae16_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ae16_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CUM_W-1:0] cfg_wdata
);

  localparam int RW   = CODE_BITS + 1;
  localparam int PW   = CUM_W + RW;
  localparam int RCW  = $clog2(MAX_RESULTS + 1);
  localparam int ICW  = $clog2(CODE_BITS + 2);
  localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] QTR  = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] Q3   = HALF | QTR;

  ae16_state_t state_r, state_nxt;
  logic [CUM_W-1:0]     total_r;
  logic [CODE_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [CNT_W-1:0]     pend_r, pend_nxt;
  logic [SYM_W-1:0]     sym_r;
  logic [RW-1:0]        range_r;
  logic [PW-1:0]        prod_hi_r;
  logic [PW-1:0]        lo_off_r, hi_off_r;
  logic                 second_r, second_nxt;
  logic [RCW-1:0]       rcnt_r, rcnt_nxt;
  logic [ICW-1:0]       iter_r, iter_nxt;
  ae16_out_t            out_r, out_nxt;
  ae16_out_t            hold_r, hold_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic                 accept, in_range;
  logic [2*CUM_W-1:0]   rd;
  logic                 ram_we;
  logic [SYM_W-1:0]     ram_addr;
  logic                 div_start, div_done;
  logic [PW-1:0]        div_num, quot;
  logic [PW-1:0]        prod_lo, prod_hi;
  logic [CUM_W-1:0]     total_eff;
  logic [RW-1:0]        lo_c, hi_c;
  logic                 emit, bit_v, under, stop;
  logic [CODE_BITS-1:0] nl, nh;

  assign in_range = 32'(in_data.symbol) < SYMBOL_COUNT;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ram_we   = accept && in_range && in_data.operation == OP_LOAD;
  assign ram_addr = accept ? in_data.symbol : sym_r;
  assign total_eff = (total_r == '0) ? CUM_W'(1) : total_r;

  ae16_ram #(.WIDTH(2 * CUM_W), .DEPTH(1 << SYM_W)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.cum_low, in_data.cum_high}),
    .rdata (rd)
  );

  assign prod_lo = PW'(rd[2*CUM_W-1:CUM_W]) * PW'(range_r);
  assign prod_hi = PW'(rd[CUM_W-1:0]) * PW'(range_r);
  assign div_num = (state_r == ST_MUL) ? prod_lo : prod_hi_r;

  ae16_div #(.NUM_W(PW), .DEN_W(CUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (total_eff),
    .done  (div_done),
    .quot  (quot)
  );

  // clamp offsets
  always_comb begin
    lo_c = (lo_off_r > PW'(range_r - 1'b1)) ? range_r - 1'b1 : lo_off_r[RW-1:0];
    hi_c = (hi_off_r > PW'(range_r)) ? range_r : hi_off_r[RW-1:0];
    if (hi_c <= lo_c) begin
      hi_c = lo_c + 1'b1;
    end
  end

  // renormalization decision
  always_comb begin
    emit  = 1'b0;
    bit_v = 1'b0;
    under = 1'b0;
    stop  = 1'b0;
    nl    = low_r;
    nh    = high_r;
    if (high_r < HALF) begin
      emit = 1'b1;
    end else if (low_r >= HALF) begin
      emit  = 1'b1;
      bit_v = 1'b1;
      nl    = low_r - HALF;
      nh    = high_r - HALF;
    end else if (low_r >= QTR && high_r < Q3) begin
      under = 1'b1;
      nl    = low_r - QTR;
      nh    = high_r - QTR;
    end else begin
      stop = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_range && in_data.operation == OP_ENCODE) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done && second_r) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: state_nxt = ST_RENORM;
      ST_RENORM: begin
        if (ovalid_r && !out_ready) begin
          state_nxt = ST_RENORM;
        end else if (stop || iter_r == ICW'(CODE_BITS + 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!ovalid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    second_nxt = second_r;
    rcnt_nxt   = rcnt_r;
    iter_nxt   = iter_r;
    out_nxt    = out_r;
    hold_nxt   = hold_r;
    ovalid_nxt = ovalid_r;
    div_start  = 1'b0;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        second_nxt = 1'b0;
        rcnt_nxt   = '0;
        iter_nxt   = '0;
      end
      ST_MUL: begin
        div_start = 1'b1;
      end
      ST_DIV: begin
        if (div_done && !second_r) begin
          second_nxt = 1'b1;
          div_start  = 1'b1;
        end
      end
      ST_CLAMP: begin
        high_nxt = CODE_BITS'(RW'(low_r) + hi_c - 1'b1);
        low_nxt  = CODE_BITS'(RW'(low_r) + lo_c);
      end
      ST_RENORM: begin
        if (!(ovalid_r && !out_ready) && !stop && iter_r != ICW'(CODE_BITS + 1)) begin
          if (emit) begin
            if (32'(rcnt_r) < MAX_RESULTS) begin
              // hold the previous result back so last_of_run can be set
              if (rcnt_r != '0) begin
                ovalid_nxt = 1'b1;
                out_nxt    = hold_r;
              end
              hold_nxt.lead_bit     = bit_v;
              hold_nxt.follow_count = pend_r;
              hold_nxt.last_of_run  = 1'b0;
              rcnt_nxt = rcnt_r + 1'b1;
            end
            pend_nxt = '0;
          end else if (under && pend_r != PENDING_MAX) begin
            pend_nxt = pend_r + 1'b1;
          end
          low_nxt  = {nl[CODE_BITS-2:0], 1'b0};
          high_nxt = {nh[CODE_BITS-2:0], 1'b1};
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        if ((!ovalid_r || out_ready) && rcnt_r != '0) begin
          ovalid_nxt          = 1'b1;
          out_nxt             = hold_r;
          out_nxt.last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= CUM_W'(1);
      low_r    <= '0;
      high_r   <= '1;
      pend_r   <= '0;
      second_r <= 1'b0;
      rcnt_r   <= '0;
      iter_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      second_r <= second_nxt;
      rcnt_r   <= rcnt_nxt;
      iter_r   <= iter_nxt;
      ovalid_r <= ovalid_nxt;
    end
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
    if (accept) begin
      sym_r <= in_data.symbol;
    end
    if (state_r == ST_READ) begin
      range_r <= RW'(high_r) - RW'(low_r) + 1'b1;
    end
    if (state_r == ST_MUL) begin
      prod_hi_r <= prod_hi;
    end
    if (div_done) begin
      if (second_r) begin
        hi_off_r <= quot;
      end else begin
        lo_off_r <= quot;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

endmodule

@@ tb/arithmetic_encoder_16bit_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arithmetic_encoder_16bit_core_tb
// Self-checking bench: loads symbol bounds, encodes symbols under several
// totals, predicts every decided bit and pending run, and checks each result.
// ----------------------------------------------------------------------------
module arithmetic_encoder_16bit_core_tb;
  import ae16_pkg::*;

  localparam int HALF     = 32768;
  localparam int QUARTER  = 16384;
  localparam int Q3       = 49152;
  localparam int WD_LIMIT = 20000;
  localparam int SETTLE   = 200;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  ae16_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  ae16_out_t        out_data;
  logic             cfg_we;
  logic [CUM_W-1:0] cfg_wdata;

  arithmetic_encoder_16bit_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [CUM_W-1:0] total_reg;
  logic [15:0]      iv_low;
  logic [15:0]      iv_high;
  logic [15:0]      pending;
  logic [27:0]      bounds [SYMBOL_COUNT_DEF];
  bit               loaded [SYMBOL_COUNT_DEF];
  ae16_out_t        expected_bits [$];

  int  errors;
  int  n_items;
  int  n_results;
  int  n_encodes;
  int  idle_cycles;
  bit  stall_hold;
  bit  stall_random;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input ae16_out_t got, input ae16_out_t exp);
    errors++;
    $display("mismatch %s: got bit %0d follow %0d last %0d, exp bit %0d follow %0d last %0d",
             what, got.lead_bit, got.follow_count, got.last_of_run,
             exp.lead_bit, exp.follow_count, exp.last_of_run);
  endtask

  function automatic void predict_item(input ae16_in_t it);
    longint unsigned tot, rng, cl, ch, lo_off, hi_off, lo, hi;
    int cnt;
    bit emit, b;
    ae16_out_t r;
    ae16_out_t run [$];
    if (it.operation == OP_LOAD) begin
      bounds[it.symbol] = {it.cum_low, it.cum_high};
      loaded[it.symbol] = 1'b1;
      return;
    end
    n_encodes++;
    tot = (total_reg == 0) ? 64'd1 : 64'(total_reg);
    cl = 64'(bounds[it.symbol][27:14]);
    ch = 64'(bounds[it.symbol][13:0]);
    rng = 64'(iv_high) - 64'(iv_low) + 1;
    lo_off = cl * rng / tot;
    hi_off = ch * rng / tot;
    if (lo_off > rng - 1) lo_off = rng - 1;
    if (hi_off > rng) hi_off = rng;
    if (hi_off <= lo_off) hi_off = lo_off + 1;
    hi = 64'(iv_low) + hi_off - 1;
    lo = 64'(iv_low) + lo_off;
    cnt = 0;
    for (int k = 0; k <= 16; k++) begin
      emit = 1'b0;
      b = 1'b0;
      if (hi < HALF) begin
        emit = 1'b1;
      end else if (lo >= HALF) begin
        emit = 1'b1;
        b = 1'b1;
        lo -= HALF;
        hi -= HALF;
      end else if (lo >= QUARTER && hi < Q3) begin
        if (pending != PENDING_MAX) pending++;
        lo -= QUARTER;
        hi -= QUARTER;
      end else begin
        break;
      end
      if (emit) begin
        if (cnt < MAX_RESULTS) begin
          r.lead_bit = b;
          r.follow_count = pending;
          r.last_of_run = 1'b0;
          run = {run, r};
          cnt++;
        end
        pending = '0;
      end
      lo = (lo << 1) & 16'hFFFF;
      hi = ((hi << 1) | 1) & 16'hFFFF;
    end
    iv_low = lo[15:0];
    iv_high = hi[15:0];
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_bits = {expected_bits, run[i]};
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_bits.size() == 0) begin
        report("unexpected", out_data, '0);
      end else begin
        if (out_data !== expected_bits[0]) report("field", out_data, expected_bits[0]);
        void'(expected_bits.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("arithmetic_encoder_16bit_core regression: fail");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_hold) out_ready <= 1'b0;
    else if (stall_random) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  task automatic send_item(input ae16_in_t it);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_total(input logic [CUM_W-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    total_reg = v;
  endtask

  function automatic ae16_in_t make_load(input int s, input int lo, input int hi);
    ae16_in_t it;
    it.operation = OP_LOAD;
    it.symbol = SYM_W'(s);
    it.cum_low = CUM_W'(lo);
    it.cum_high = CUM_W'(hi);
    return it;
  endfunction

  function automatic ae16_in_t make_encode(input int s);
    ae16_in_t it;
    it.operation = OP_ENCODE;
    it.symbol = SYM_W'(s);
    it.cum_low = CUM_W'($urandom());
    it.cum_high = CUM_W'($urandom());
    return it;
  endfunction

  function automatic int pick_loaded;
    int s;
    do s = $urandom_range(0, 255); while (!loaded[s]);
    return s;
  endfunction

  task automatic test_directed;
    send_item(make_load(0, 0, 1));
    send_item(make_load(1, 0, 16383));
    send_item(make_load(2, 16383, 16383));
    send_item(make_load(3, 9000, 100));
    send_item(make_load(255, 16382, 16383));
    send_item(make_load(128, 5461, 10922));
    send_item(make_encode(1));
    send_item(make_encode(0));
    write_total(16383);
    send_item(make_encode(255));
    send_item(make_encode(2));
    send_item(make_encode(3));
    send_item(make_encode(128));
    send_item(make_encode(0));
    send_item(make_encode(1));
    write_total(0);
    send_item(make_encode(0));
    send_item(make_encode(3));
    write_total(3);
    for (int i = 0; i < 6; i++) send_item(make_encode(128));
  endtask

  // straddling middle: lots of underflow shifts to grow the pending count
  task automatic test_underflow;
    write_total(16383);
    send_item(make_load(10, 8191, 8192));
    send_item(make_load(11, 4000, 12383));
    for (int i = 0; i < 30; i++) send_item(make_encode(($urandom_range(0, 1)) ? 10 : 11));
  endtask

  task automatic test_random(input int n, input logic [CUM_W-1:0] tot);
    int lo, hi, k;
    ae16_in_t it;
    write_total(tot);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 3) begin
        lo = $urandom_range(0, 16383);
        hi = $urandom_range(0, 16383);
        if (k != 0 && lo > hi) begin
          int t;
          t = lo; lo = hi; hi = t;
        end
        send_item(make_load($urandom_range(0, 255), lo, hi));
      end else begin
        send_item(make_encode(pick_loaded()));
      end
    end
  endtask

  task automatic test_backpressure;
    fork
      begin
        stall_hold = 1'b1;
        repeat (600) @(posedge clk);
        stall_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_item(make_encode(pick_loaded()));
    join
    drain();
  endtask

  initial begin
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_encodes = 0;
    idle_cycles = 0;
    stall_hold = 1'b0;
    stall_random = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    total_reg = 1;
    iv_low = '0;
    iv_high = 16'hFFFF;
    pending = '0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_underflow();
    stall_random = 1'b1;
    test_random(130, 16383);
    test_backpressure();
    test_random(130, CUM_W'($urandom_range(1, 16383)));
    test_random(110, CUM_W'($urandom_range(1, 64)));
    stall_random = 1'b0;
    drain();
    $display("covered %0d items (%0d encodes), %0d bit runs checked, totals 0..16383",
             n_items, n_encodes, n_results);
    $display("with underflow runs, out-of-order bounds and long output stalls");
    if (errors == 0 && expected_bits.size() == 0) begin
      $display("arithmetic_encoder_16bit_core regression: pass");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_bits.size());
      $display("arithmetic_encoder_16bit_core regression: fail");
    end
    $finish;
  end

endmodule
